// File: sv/accc_pkg.sv
// shared constants and types of the adaptive command code coder
// used by accc_ctrl, accc_dp and adaptive_command_code_coder_core
package accc_pkg;

	localparam int SYM_W         = 5;
	localparam int WIN_W         = 8;
	localparam int CW_W          = 8;
	localparam int LEN_W         = 4;
	localparam int CNT_W         = 7;
	localparam int MODE_W        = 3;
	localparam int PHASE_W       = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 5;

	localparam int NUM_SYMBOLS_DEF = 32;

	// coding modes
	localparam logic [MODE_W-1:0] MODE_PLAIN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ONE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TWO   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_THREE = 3'd4;

	// codeword lengths
	localparam int LEN_PLAIN = 5;
	localparam int LEN_ESC2  = 6;
	localparam int LEN_ESC3  = 7;
	localparam int LEN_ESC4  = 8;

	// startup phases and their adaptation thresholds
	localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_STEADY = 2'd2;
	localparam int THRESH_FIRST  = 5;
	localparam int THRESH_SECOND = 20;
	localparam int THRESH_STEADY = 100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THIRD     = 2'd3;

	// reset shortcut symbols
	localparam logic [SYM_W-1:0] RST_FIRST  = 5'd17;
	localparam logic [SYM_W-1:0] RST_SECOND = 5'd18;
	localparam logic [SYM_W-1:0] RST_THIRD  = 5'd19;

	// starting ranking of the adaptation scan
	localparam logic [SYM_W-1:0] SCAN_S1 = 5'd0;
	localparam logic [SYM_W-1:0] SCAN_S2 = 5'd1;
	localparam logic [SYM_W-1:0] SCAN_S3 = 5'd2;

	typedef struct packed {
		logic accept;
		logic update;
		logic scan;
		logic cost;
		logic decide;
	} accc_cmd_t;

	typedef struct packed {
		logic adapt_due;
		logic scan_last;
	} accc_stat_t;

endpackage

// File: sv/accc_ctrl.sv
// controller of the adaptive command code coder: item handshake and sequencing
// depends on accc_pkg
module accc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  accc_pkg::accc_stat_t   stat,
	output accc_pkg::accc_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UPD    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_COST   = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		state_nx   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nx = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_nx   = stat.adapt_due ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_nx = ST_DRAIN;
			end
			// last scanned count is ranked here
			ST_DRAIN: begin
				state_nx = ST_COST;
			end
			ST_COST: begin
				cmd.cost = 1'b1;
				state_nx = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_nx   = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/accc_dp.sv
// datapath of the adaptive command code coder: coding, count memory, adaptation
// depends on accc_pkg
module accc_dp #(
	parameter int NUM_SYMBOLS = accc_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  accc_pkg::accc_cmd_t                 cmd,
	output accc_pkg::accc_stat_t                stat,
	input  logic                                cfg_we,
	input  logic [accc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [accc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [accc_pkg::SYM_W-1:0]          symbol,
	input  logic [accc_pkg::WIN_W-1:0]          bit_window,
	output logic [accc_pkg::CW_W-1:0]           codeword,
	output logic [accc_pkg::LEN_W-1:0]          bit_count,
	output logic [accc_pkg::SYM_W-1:0]          decoded_symbol
);

	localparam int SYM_W  = accc_pkg::SYM_W;
	localparam int CNT_W  = accc_pkg::CNT_W;
	localparam int IDX_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int TOT_W  = CNT_W + IDX_W;
	localparam int SZ_W   = TOT_W + 3;
	localparam logic [SYM_W:0]   NUM_L     = (SYM_W + 1)'(NUM_SYMBOLS);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SYMBOLS - 1);

	// live coding state
	logic [accc_pkg::MODE_W-1:0]  mode_q;
	logic [SYM_W-1:0]             first_q, second_q, third_q;
	logic                         dir_q;
	logic [CNT_W-1:0]             since_q;
	logic [accc_pkg::PHASE_W-1:0] phase_q;

	// count memory with reset-cleared valid bits
	logic [CNT_W-1:0]       cnt_mem [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] cnt_vld_q;
	logic [CNT_W-1:0]       rd_q;
	logic                   rd_vld_q;
	logic [IDX_W-1:0]       rd_addr;
	logic                   rd_en;
	logic [CNT_W-1:0]       rd_cnt;

	// item held for the count update
	logic [SYM_W-1:0] sym_s1;
	logic             in_range_s1;

	// adaptation scan
	logic [IDX_W-1:0] scan_idx_q, scan_didx_q;
	logic             scan_dv_q;
	logic [SYM_W-1:0] s1_q, s2_q, s3_q;
	logic [CNT_W-1:0] c1_q, c2_q, c3_q;
	logic [TOT_W-1:0] total_q;
	logic [SZ_W-1:0]  sz1_q, sz2_q, sz3_q, sz4_q;

	logic [accc_pkg::MODE_W-1:0] mode_eff;
	logic [accc_pkg::CW_W-1:0]   cw_res;
	logic [accc_pkg::LEN_W-1:0]  len_res;
	logic [SYM_W-1:0]            sym_res;
	logic                        sym_in_range;
	logic [CNT_W-1:0]            since_nx;
	logic [TOT_W-1:0]            rest2, rest3, rest4;
	logic [SZ_W-1:0]             best;
	logic [SYM_W-1:0]            didx_sym;

	always_comb begin
		mode_eff = mode_q;
		if (mode_q != accc_pkg::MODE_PLAIN && mode_q != accc_pkg::MODE_ONE &&
			mode_q != accc_pkg::MODE_TWO) mode_eff = accc_pkg::MODE_THREE;
	end

	// encode or decode the item with the current code
	always_comb begin
		cw_res  = '0;
		sym_res = symbol;
		len_res = accc_pkg::LEN_W'(accc_pkg::LEN_PLAIN);
		if (!dir_q) begin
			if (mode_eff == accc_pkg::MODE_PLAIN) begin
				cw_res = accc_pkg::CW_W'(symbol);
			end else if (symbol == first_q) begin
				cw_res  = accc_pkg::CW_W'(1);
				len_res = accc_pkg::LEN_W'(1);
			end else if (mode_eff != accc_pkg::MODE_ONE && symbol == second_q) begin
				cw_res  = accc_pkg::CW_W'(1);
				len_res = accc_pkg::LEN_W'(2);
			end else if (mode_eff == accc_pkg::MODE_THREE && symbol == third_q) begin
				cw_res  = accc_pkg::CW_W'(1);
				len_res = accc_pkg::LEN_W'(3);
			end else begin
				cw_res  = accc_pkg::CW_W'(symbol);
				len_res = accc_pkg::LEN_W'(mode_eff) + accc_pkg::LEN_W'(4);
			end
		end else begin
			if (mode_eff == accc_pkg::MODE_PLAIN) begin
				sym_res = bit_window[7:3];
			end else if (bit_window[7]) begin
				sym_res = first_q;
				len_res = accc_pkg::LEN_W'(1);
			end else if (mode_eff != accc_pkg::MODE_ONE && bit_window[6]) begin
				sym_res = second_q;
				len_res = accc_pkg::LEN_W'(2);
			end else if (mode_eff == accc_pkg::MODE_THREE && bit_window[5]) begin
				sym_res = third_q;
				len_res = accc_pkg::LEN_W'(3);
			end else begin
				len_res = accc_pkg::LEN_W'(mode_eff) + accc_pkg::LEN_W'(4);
				case (mode_eff)
					accc_pkg::MODE_ONE: sym_res = bit_window[6:2];
					accc_pkg::MODE_TWO: sym_res = bit_window[5:1];
					default:            sym_res = bit_window[4:0];
				endcase
			end
		end
	end

	assign sym_in_range = {1'b0, sym_res} < NUM_L;

	// one read port shared by the item lookup and the scan
	assign rd_en   = (cmd.accept && sym_in_range) || cmd.scan;
	assign rd_addr = cmd.scan ? scan_idx_q : sym_res[IDX_W-1:0];
	assign rd_cnt  = rd_vld_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= cnt_mem[rd_addr];
		if (cmd.update && in_range_s1) cnt_mem[sym_s1[IDX_W-1:0]] <= rd_cnt + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (rd_en) rd_vld_q <= cnt_vld_q[rd_addr];
			if (cmd.decide) cnt_vld_q <= '0;
			else if (cmd.update && in_range_s1) cnt_vld_q[sym_s1[IDX_W-1:0]] <= 1'b1;
		end
	end

	// adaptation schedule
	assign since_nx = since_q + CNT_W'(1);
	assign stat.adapt_due =
		(phase_q == accc_pkg::PHASE_FIRST  && since_nx > CNT_W'(accc_pkg::THRESH_FIRST)) ||
		(phase_q == accc_pkg::PHASE_SECOND && since_nx > CNT_W'(accc_pkg::THRESH_SECOND)) ||
		(phase_q == accc_pkg::PHASE_STEADY && since_nx > CNT_W'(accc_pkg::THRESH_STEADY));
	assign stat.scan_last = scan_idx_q == LAST_IDX;

	// output register and item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			codeword       <= cw_res;
			bit_count      <= len_res;
			decoded_symbol <= sym_res;
			sym_s1         <= sym_res;
			in_range_s1    <= sym_in_range;
		end
	end

	// scan ranking, costs
	assign didx_sym = SYM_W'(scan_didx_q);
	assign rest2    = total_q - TOT_W'(c1_q);
	assign rest3    = rest2 - TOT_W'(c2_q);
	assign rest4    = rest3 - TOT_W'(c3_q);

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			scan_idx_q <= '0;
			s1_q       <= accc_pkg::SCAN_S1;
			s2_q       <= accc_pkg::SCAN_S2;
			s3_q       <= accc_pkg::SCAN_S3;
			c1_q       <= '0;
			c2_q       <= '0;
			c3_q       <= '0;
			total_q    <= '0;
		end
		if (cmd.scan) begin
			scan_idx_q  <= scan_idx_q + IDX_W'(1);
			scan_didx_q <= scan_idx_q;
		end
		if (scan_dv_q) begin
			total_q <= total_q + TOT_W'(rd_cnt);
			if (rd_cnt > c3_q) begin
				if (rd_cnt > c1_q) begin
					s3_q <= s2_q;     c3_q <= c2_q;
					s2_q <= s1_q;     c2_q <= c1_q;
					s1_q <= didx_sym; c1_q <= rd_cnt;
				end else if (rd_cnt > c2_q) begin
					s3_q <= s2_q;     c3_q <= c2_q;
					s2_q <= didx_sym; c2_q <= rd_cnt;
				end else begin
					s3_q <= didx_sym; c3_q <= rd_cnt;
				end
			end
		end
		if (cmd.cost) begin
			sz1_q <= SZ_W'(total_q) * SZ_W'(accc_pkg::LEN_PLAIN);
			sz2_q <= SZ_W'(c1_q) + SZ_W'(rest2) * SZ_W'(accc_pkg::LEN_ESC2);
			sz3_q <= SZ_W'(c1_q) + (SZ_W'(c2_q) << 1) + SZ_W'(rest3) * SZ_W'(accc_pkg::LEN_ESC3);
			sz4_q <= SZ_W'(c1_q) + (SZ_W'(c2_q) << 1) + SZ_W'(c3_q) * SZ_W'(3)
				+ SZ_W'(rest4) * SZ_W'(accc_pkg::LEN_ESC4);
		end
	end

	always_comb begin
		best = sz1_q;
		if (sz2_q < best) best = sz2_q;
		if (sz3_q < best) best = sz3_q;
		if (sz4_q < best) best = sz4_q;
	end

	// live state: configuration, schedule and adaptation result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= accc_pkg::MODE_THREE;
			first_q   <= accc_pkg::RST_FIRST;
			second_q  <= accc_pkg::RST_SECOND;
			third_q   <= accc_pkg::RST_THIRD;
			dir_q     <= 1'b0;
			since_q   <= '0;
			phase_q   <= accc_pkg::PHASE_FIRST;
			scan_dv_q <= 1'b0;
		end else begin
			scan_dv_q <= cmd.scan;
			if (cfg_we) begin
				unique case (cfg_index)
					accc_pkg::CFG_DIRECTION: dir_q    <= cfg_data[0];
					accc_pkg::CFG_FIRST:     first_q  <= cfg_data;
					accc_pkg::CFG_SECOND:    second_q <= cfg_data;
					accc_pkg::CFG_THIRD:     third_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.update) begin
				if (stat.adapt_due) begin
					since_q <= '0;
					if (phase_q == accc_pkg::PHASE_FIRST) phase_q <= accc_pkg::PHASE_SECOND;
					else if (phase_q == accc_pkg::PHASE_SECOND)
						phase_q <= accc_pkg::PHASE_STEADY;
				end else begin
					since_q <= since_nx;
				end
			end
			if (cmd.decide) begin
				if (best == sz1_q) begin
					mode_q <= accc_pkg::MODE_PLAIN;
				end else if (best == sz2_q) begin
					mode_q  <= accc_pkg::MODE_ONE;
					first_q <= s1_q;
				end else if (best == sz3_q) begin
					mode_q   <= accc_pkg::MODE_TWO;
					first_q  <= s1_q;
					second_q <= s2_q;
				end else begin
					mode_q   <= accc_pkg::MODE_THREE;
					first_q  <= s1_q;
					second_q <= s2_q;
					third_q  <= s3_q;
				end
			end
		end
	end

endmodule

// File: sv/adaptive_command_code_coder_core.sv
// top level of the adaptive command code coder
// depends on accc_pkg, accc_ctrl and accc_dp
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------
//  in      | in_valid / in_stall | symbol, bit_window
//  out     | out_valid/out_stall | codeword, bit_count, decoded_symbol
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// an item is coded and its count read, then the count is written back
// a re-adaptation scans the count memory through its single read port, then ranks
// the last count, computes the costs and picks the cheapest code; reset clears the
// count memory through its valid bits at once, no clearing pass; a result waits in
// the output register, and a new item is taken when idle and it is free or taken
module adaptive_command_code_coder_core #(
	parameter int NUM_SYMBOLS = accc_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [accc_pkg::SYM_W-1:0]        symbol,
	input  logic [accc_pkg::WIN_W-1:0]        bit_window,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [accc_pkg::CW_W-1:0]         codeword,
	output logic [accc_pkg::LEN_W-1:0]        bit_count,
	output logic [accc_pkg::SYM_W-1:0]        decoded_symbol,
	input  logic                              cfg_we,
	input  logic [accc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [accc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	accc_pkg::accc_cmd_t  cmd;
	accc_pkg::accc_stat_t stat;

	accc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	accc_dp #(
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.symbol         (symbol),
		.bit_window     (bit_window),
		.codeword       (codeword),
		.bit_count      (bit_count),
		.decoded_symbol (decoded_symbol)
	);

endmodule
